@@ rtl/assert_macros.svh @@
// Assertion macros used by limited_weighted_interval_select.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_RST(label, clk, prop) \
	label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_RST(label, clk, prop)
`endif
`endif

@@ rtl/lwis_pkg.sv @@
package lwis_pkg;
	localparam int MaxIntervals = 1024;
	localparam int PickLimit    = 4;
	localparam int Row          = PickLimit + 1;
	localparam int IdxW         = $clog2(MaxIntervals);
	localparam int CntW         = IdxW + 1;
	localparam int CellDepth    = (MaxIntervals + 1) * Row;
	localparam int CellW        = $clog2(CellDepth);
	localparam int TotW         = 33;
	localparam int ChoiceW      = PickLimit * IdxW;
	// Cell word: valid, total, choice list.
	localparam int DpW          = 1 + TotW + ChoiceW;
	localparam int BoundW       = 60;

	typedef struct packed {
		logic [29:0] left_end;
		logic [29:0] right_end;
		logic [29:0] weight;
		logic        final_item;
	} in_item_t;

	typedef struct packed {
		logic [9:0] chosen_index;
		logic       last_of_answer;
		logic       empty_answer;
		logic       overflow;
	} out_item_t;

	typedef enum logic [4:0] {
		ST_LOAD, ST_SORT_RD, ST_SORT_WT, ST_SORT_CMP, ST_SORT_SH, ST_SORT_PUT,
		ST_DP_INIT, ST_DP_RDI, ST_DP_WTI, ST_DP_ID, ST_BS_RD, ST_BS_WT,
		ST_BS_CMP, ST_DP_RDJ, ST_DP_WTJ, ST_DP_WR, ST_FIN_RD, ST_FIN_WT,
		ST_FIN_CMP, ST_EMIT
	} state_t;
endpackage

@@ rtl/lwis_ram.sv @@
module lwis_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	// Single write port, registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/limited_weighted_interval_select.sv @@
// Loads one interval per cycle while busy is low. On the interval marked final, busy rises
// and the block works on the stored set. First comes an insertion sort by right endpoint.
// The table is then seeded. Each sorted interval is fetched, a binary search is run over
// the sorted entries before it, and a table cell is written for each of the five pick
// counts. A pass over the final row follows. The one to four results come on consecutive
// cycles, one strobe each, and busy falls after the last; the receiver cannot stall. The
// memory ports of the sort and the table walk set the time.
`include "assert_macros.svh"
module limited_weighted_interval_select import lwis_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  in_item,
	output logic      strobe,
	output out_item_t result
);
	state_t state_q, state_d;

	logic [CntW-1:0]  cnt_q;
	logic             drop_q;
	logic [CntW-1:0]  i_q, p_q, lo_q, hi_q, k_q;
	logic [IdxW-1:0]  v_q, id_q;
	logic [29:0]      vr_q, left_q, w_q;
	logic [2:0]       j_q;
	logic [DpW-1:0]   prev_q;
	logic [TotW-1:0]  best_t_q;
	logic [ChoiceW-1:0] best_c_q;
	logic [2:0]       best_l_q, emit_q;

	// Memories.
	logic             b_we;  logic [IdxW-1:0] b_wa, b_ra; logic [BoundW+29:0] b_wd, b_rd;
	logic             s_we;  logic [IdxW-1:0] s_wa, s_ra; logic [IdxW-1:0] s_wd, s_rd;
	logic             d_we;  logic [CellW-1:0] d_wa, d_ra; logic [DpW-1:0] d_wd, d_rd;

	lwis_ram #(.Width(BoundW + 30), .Depth(MaxIntervals)) u_bounds (
		.clk, .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_rd));
	lwis_ram #(.Width(IdxW), .Depth(MaxIntervals)) u_order (
		.clk, .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
	lwis_ram #(.Width(DpW), .Depth(CellDepth)) u_dp (
		.clk, .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(d_ra), .rdata(d_rd));

	function automatic logic [CellW-1:0] cell_addr(logic [CntW-1:0] r, logic [2:0] c);
		cell_addr = CellW'(r * Row + c);
	endfunction

	// Lexicographic compare of two lists of equal length len.
	function automatic logic lex_less(logic [ChoiceW-1:0] a, logic [ChoiceW-1:0] b,
			logic [2:0] len);
		logic res, done;
		res = 1'b0; done = 1'b0;
		for (int t = 0; t < PickLimit; t++) begin
			if (!done && 3'(t) < len && a[t*IdxW +: IdxW] != b[t*IdxW +: IdxW]) begin
				res = a[t*IdxW +: IdxW] < b[t*IdxW +: IdxW];
				done = 1'b1;
			end
		end
		lex_less = res;
	endfunction

	logic accept;
	assign accept = start && !busy;
	assign busy = state_q != ST_LOAD;

	// Fields read back.
	logic [29:0] rd_right, rd_left, rd_w;
	assign rd_left  = b_rd[89:60];
	assign rd_right = b_rd[59:30];
	assign rd_w     = b_rd[29:0];

	// The sorted entry below the insertion point goes after the interval being placed.
	logic sort_shift;
	assign sort_shift = rd_right > vr_q || (rd_right == vr_q && s_rd > v_q);

	logic [CntW-1:0] mid;
	assign mid = lo_q + ((hi_q - lo_q) >> 1);

	// Candidate built from the source cell in d_rd.
	logic             src_v;
	logic [TotW-1:0]  src_t, nw;
	logic [ChoiceW-1:0] src_c, cand;
	logic             take;
	always_comb begin
		logic ins;
		logic [ChoiceW-1:0] src_sh;
		src_v  = d_rd[DpW-1];
		src_t  = d_rd[ChoiceW +: TotW];
		src_c  = d_rd[ChoiceW-1:0];
		src_sh = src_c << IdxW;
		nw     = src_t + TotW'(w_q);
		cand   = '0;
		ins    = 1'b0;
		for (int t = 0; t < PickLimit; t++) begin
			if (3'(t) < j_q - 3'd1) begin
				if (!ins && src_c[t*IdxW +: IdxW] < id_q) begin
					cand[t*IdxW +: IdxW] = src_c[t*IdxW +: IdxW];
				end else if (!ins) begin
					cand[t*IdxW +: IdxW] = id_q;
					ins = 1'b1;
				end else begin
					cand[t*IdxW +: IdxW] = src_sh[t*IdxW +: IdxW];
				end
			end else if (3'(t) == j_q - 3'd1) begin
				cand[t*IdxW +: IdxW] = ins ? src_sh[t*IdxW +: IdxW] : id_q;
			end
		end
		take = src_v && (!prev_q[DpW-1] || nw > prev_q[ChoiceW +: TotW] ||
			(nw == prev_q[ChoiceW +: TotW] && lex_less(cand, prev_q[ChoiceW-1:0], j_q)));
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD:     if (accept && in_item.final_item) state_d = ST_SORT_RD;
			ST_SORT_RD:  state_d = (i_q >= cnt_q) ? ST_DP_INIT : ST_SORT_WT;
			ST_SORT_WT:  state_d = (p_q == '0) ? ST_SORT_PUT : ST_SORT_CMP;
			ST_SORT_CMP: state_d = ST_SORT_SH;
			ST_SORT_SH:  state_d = sort_shift ? ST_SORT_WT : ST_SORT_PUT;
			ST_SORT_PUT: state_d = ST_SORT_RD;
			ST_DP_INIT:  state_d = (j_q == 3'(PickLimit)) ? ST_DP_RDI : ST_DP_INIT;
			ST_DP_RDI:   state_d = (i_q >= cnt_q) ? ST_FIN_RD : ST_DP_WTI;
			ST_DP_WTI:   state_d = ST_DP_ID;
			ST_DP_ID:    state_d = ST_BS_RD;
			ST_BS_RD:    state_d = (lo_q < hi_q) ? ST_BS_WT : ST_DP_RDJ;
			ST_BS_WT:    state_d = ST_BS_CMP;
			ST_BS_CMP:   state_d = ST_BS_RD;
			ST_DP_RDJ:   state_d = ST_DP_WTJ;
			ST_DP_WTJ:   state_d = ST_DP_WR;
			ST_DP_WR:    state_d = (j_q == 3'(PickLimit)) ? ST_DP_RDI : ST_DP_RDJ;
			ST_FIN_RD:   state_d = ST_FIN_WT;
			ST_FIN_WT:   state_d = ST_FIN_CMP;
			ST_FIN_CMP:  state_d = (j_q == 3'(PickLimit)) ? ST_EMIT : ST_FIN_RD;
			ST_EMIT:     state_d = (best_l_q == '0 || emit_q + 3'd1 == best_l_q) ?
				ST_LOAD : ST_EMIT;
			default:     state_d = ST_LOAD;
		endcase
	end

	// Memory control.
	always_comb begin
		b_we = 1'b0; b_wa = cnt_q[IdxW-1:0];
		b_wd = {in_item.left_end, in_item.right_end, in_item.weight};
		b_ra = v_q;
		s_we = 1'b0; s_wa = p_q[IdxW-1:0]; s_wd = v_q; s_ra = '0;
		d_we = 1'b0; d_wa = cell_addr('0, j_q); d_wd = '0; d_ra = '0;
		case (state_q)
			ST_LOAD: b_we = accept && cnt_q < CntW'(MaxIntervals);
			ST_SORT_RD: b_ra = i_q[IdxW-1:0];
			ST_SORT_WT: begin
				s_ra = IdxW'(p_q - 1'b1);
			end
			ST_SORT_CMP: begin
				s_ra = IdxW'(p_q - 1'b1);
				b_ra = s_rd;
			end
			ST_SORT_SH: begin
				s_we = sort_shift; s_wd = s_rd;
			end
			ST_SORT_PUT: s_we = 1'b1;
			ST_DP_INIT: begin
				d_we = 1'b1;
				d_wd = {(j_q == '0), TotW'(0), ChoiceW'(0)};
			end
			ST_DP_RDI: s_ra = i_q[IdxW-1:0];
			ST_DP_WTI: b_ra = s_rd;
			ST_BS_RD: s_ra = mid[IdxW-1:0];
			ST_BS_WT: b_ra = s_rd;
			ST_DP_RDJ, ST_DP_WTJ:
				d_ra = (j_q == '0) ? cell_addr(i_q, '0) : cell_addr(k_q, j_q - 3'd1);
			ST_DP_WR: begin
				d_we = 1'b1; d_wa = cell_addr(i_q + 1'b1, j_q);
				d_wd = (j_q != '0 && take) ? {1'b1, nw, cand} : prev_q;
				d_ra = cell_addr(i_q, j_q + 3'd1);
			end
			ST_FIN_RD, ST_FIN_WT: d_ra = cell_addr(cnt_q, j_q);
			default: ;
		endcase
	end

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			drop_q  <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			emit_q  <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_LOAD: if (accept) begin
					if (cnt_q < CntW'(MaxIntervals)) cnt_q <= cnt_q + 1'b1;
					else drop_q <= 1'b1;
					i_q <= '0; j_q <= '0; emit_q <= '0;
				end
				ST_SORT_RD: begin
					v_q <= i_q[IdxW-1:0]; p_q <= i_q;
					if (i_q >= cnt_q) j_q <= '0;
				end
				ST_SORT_WT: vr_q <= rd_right;
				ST_SORT_SH: if (sort_shift) p_q <= p_q - 1'b1;
				ST_SORT_PUT: i_q <= i_q + 1'b1;
				ST_DP_INIT: begin
					j_q <= j_q + 3'd1;
					if (j_q == 3'(PickLimit)) i_q <= '0;
				end
				ST_DP_RDI: if (i_q >= cnt_q) begin
					j_q <= '0; best_l_q <= '0;
					best_t_q <= '0; best_c_q <= '0;
				end
				ST_DP_WTI: id_q <= s_rd;
				ST_DP_ID: begin
					left_q <= rd_left; w_q <= rd_w;
					lo_q <= '0; hi_q <= i_q; j_q <= '0;
				end
				ST_BS_CMP: begin
					if (rd_right < left_q) lo_q <= mid + 1'b1;
					else hi_q <= mid;
				end
				ST_BS_RD: k_q <= lo_q;
				// The previous row's cell for this pick count was read by the last write.
				ST_DP_RDJ: if (j_q != '0) prev_q <= d_rd;
				ST_DP_WTJ: if (j_q == '0) prev_q <= d_rd;
				ST_DP_WR: begin
					j_q <= j_q + 3'd1;
					if (j_q == 3'(PickLimit)) i_q <= i_q + 1'b1;
				end
				ST_FIN_CMP: begin
					if (j_q != '0 && d_rd[DpW-1] && (d_rd[ChoiceW +: TotW] > best_t_q ||
						(d_rd[ChoiceW +: TotW] == best_t_q && best_l_q != '0 &&
						lex_less(d_rd[ChoiceW-1:0], best_c_q,
						(j_q < best_l_q) ? j_q : best_l_q)))) begin
						best_t_q <= d_rd[ChoiceW +: TotW];
						best_c_q <= d_rd[ChoiceW-1:0];
						best_l_q <= j_q;
					end
					j_q <= j_q + 3'd1;
				end
				ST_EMIT: begin
					emit_q <= emit_q + 3'd1;
					if (state_d == ST_LOAD) begin
						cnt_q <= '0; drop_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// Outputs.
	always_comb begin
		strobe = state_q == ST_EMIT;
		result.chosen_index   = (best_l_q == '0) ? '0 : best_c_q[emit_q[1:0]*IdxW +: IdxW];
		result.last_of_answer = best_l_q == '0 || emit_q + 3'd1 == best_l_q;
		result.empty_answer   = best_l_q == '0;
		result.overflow       = drop_q;
	end

	`ASSERT_IMPL(a_no_accept_busy, clk, arst_n, busy |-> !accept)
	`ASSERT_IMPL(a_emit_count, clk, arst_n, strobe |-> emit_q < 3'(PickLimit))
	`ASSERT_IMPL(a_last_ends, clk, arst_n, (strobe && result.last_of_answer) |=> !strobe)
	`ASSERT_RST(a_reset_idle, clk, !arst_n |=> !busy)
endmodule
